FILE: rtl/core/prpd_pkg.sv
// Package for the run-length plane decoder: state encoding, controller and
// datapath interface structs, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package prpd_pkg;

    localparam int CfgWidth   = 11;
    localparam int CfgIdxBits = 3;
    localparam int AddrBits   = 22;
    localparam int PosBits    = 11;
    localparam int OutPosBits = 10;
    localparam int RunBits    = 6;
    localparam int RowStepBits = 14;

    localparam logic [CfgIdxBits-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_PLANE_COUNT     = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_BYTES_PER_PIXEL = 3'd3;

    localparam logic [1:0] RUN_MARK_BITS = 2'b11;

    typedef enum logic [1:0] {
        ST_CODE,
        ST_VALUE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic restart;
        logic latch_count;
        logic emit;
        logic literal;
        logic run_start;
    } cmd_t;

    typedef struct packed {
        logic is_run_code;
        logic run_empty;
        logic run_single;
        logic run_last;
        logic completes;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/prpd_datapath.sv
// Datapath of the run-length plane decoder: configuration registers, walk
// position, run counter, address generation and the result register.
// Depends on prpd_pkg.
`default_nettype none

module prpd_datapath #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [prpd_pkg::CfgIdxBits-1:0]      cfg_index,
    input  wire logic [prpd_pkg::CfgWidth-1:0]        cfg_wdata,
    input  wire logic [7:0]                           s_code_byte,
    input  wire prpd_pkg::cmd_t                       cmd,
    output prpd_pkg::status_t                         status,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [7:0]                                m_pixel_value,
    output logic [prpd_pkg::OutPosBits-1:0]           m_column,
    output logic [prpd_pkg::OutPosBits-1:0]           m_row,
    output logic [1:0]                                m_plane,
    output logic [prpd_pkg::AddrBits-1:0]             m_byte_address,
    output logic                                      m_last_of_run,
    output logic                                      m_image_complete
);

    localparam int CfgMax = (1 << prpd_pkg::CfgWidth) - 1;
    localparam int DimLim = (MAX_DIM > CfgMax) ? CfgMax : MAX_DIM;
    localparam logic [prpd_pkg::CfgWidth-1:0] DIM_LIM = prpd_pkg::CfgWidth'(DimLim);

    localparam int PB = prpd_pkg::PosBits;
    localparam int AB = prpd_pkg::AddrBits;
    localparam int RB = prpd_pkg::RunBits;

    logic [prpd_pkg::CfgWidth-1:0] width_reg, height_reg;
    logic [2:0]                    planes_reg, bpp_reg;

    logic [PB-1:0] w_eff, h_eff;
    logic [2:0]    np_eff, bpp_eff;

    logic [RB-1:0] pending_reg, pending_next;
    logic [7:0]    value_reg, value_next;
    logic [RB-1:0] rem_reg, rem_next;
    logic [PB-1:0] col_reg, col_next;
    logic [PB-1:0] row_reg, row_next;
    logic [1:0]    plane_reg, plane_next;
    logic [AB-1:0] row_base_reg, row_base_next;
    logic [AB-1:0] addr_reg, addr_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_value_reg;
    logic [prpd_pkg::OutPosBits-1:0] out_col_reg, out_row_reg;
    logic [1:0]    out_plane_reg;
    logic [AB-1:0] out_addr_reg;
    logic          out_last_reg, out_complete_reg;

    logic [PB-1:0] room;
    logic [RB-1:0] clip_n;
    logic          line_end, plane_last, row_last, elem_last;
    logic [prpd_pkg::RowStepBits-1:0] row_step;
    logic [AB-1:0] next_base;
    logic [7:0]    emit_value;
    logic          cfg_hit;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = PB'(1);
        end else if (width_reg > DIM_LIM) begin
            w_eff = DIM_LIM;
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = PB'(1);
        end else if (height_reg > DIM_LIM) begin
            h_eff = DIM_LIM;
        end else begin
            h_eff = height_reg;
        end
        if (planes_reg == 3'd0) begin
            np_eff = 3'd1;
        end else if (planes_reg > 3'd4) begin
            np_eff = 3'd4;
        end else begin
            np_eff = planes_reg;
        end
        if (bpp_reg < 3'd3) begin
            bpp_eff = 3'd3;
        end else if (bpp_reg > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = bpp_reg;
        end
    end

    assign cfg_hit = cfg_we && (cfg_index == prpd_pkg::REG_IMAGE_WIDTH
                             || cfg_index == prpd_pkg::REG_IMAGE_HEIGHT
                             || cfg_index == prpd_pkg::REG_PLANE_COUNT
                             || cfg_index == prpd_pkg::REG_BYTES_PER_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= prpd_pkg::CfgWidth'(1);
            height_reg <= prpd_pkg::CfgWidth'(1);
            planes_reg <= 3'd3;
            bpp_reg    <= 3'd3;
        end else if (cfg_hit) begin
            case (cfg_index)
                prpd_pkg::REG_IMAGE_WIDTH:     width_reg  <= cfg_wdata;
                prpd_pkg::REG_IMAGE_HEIGHT:    height_reg <= cfg_wdata;
                prpd_pkg::REG_PLANE_COUNT:     planes_reg <= cfg_wdata[2:0];
                prpd_pkg::REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign room     = w_eff - col_reg;
    assign clip_n   = ({{(PB-RB){1'b0}}, pending_reg} < room) ? pending_reg : room[RB-1:0];
    assign line_end   = (col_reg + PB'(1)) == w_eff;
    assign plane_last = ({1'b0, plane_reg} + 3'd1) >= np_eff;
    assign row_last   = (row_reg + PB'(1)) >= h_eff;
    assign row_step   = prpd_pkg::RowStepBits'(w_eff) * prpd_pkg::RowStepBits'(bpp_eff);
    assign next_base  = row_base_reg + AB'(row_step);
    assign emit_value = (cmd.literal || cmd.run_start) ? s_code_byte : value_reg;

    always_comb begin
        if (cmd.literal) begin
            elem_last = 1'b1;
        end else if (cmd.run_start) begin
            elem_last = (clip_n == RB'(1));
        end else begin
            elem_last = (rem_reg == RB'(1));
        end
    end

    assign status.is_run_code = (s_code_byte[7:6] == prpd_pkg::RUN_MARK_BITS);
    assign status.run_empty   = (clip_n == '0);
    assign status.run_single  = (clip_n == RB'(1));
    assign status.run_last    = (rem_reg == RB'(1));
    assign status.completes   = line_end && plane_last && row_last;
    assign status.out_free    = !out_valid_reg || m_ready;

    always_comb begin
        pending_next   = pending_reg;
        value_next     = value_reg;
        rem_next       = rem_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        plane_next     = plane_reg;
        row_base_next  = row_base_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.restart) begin
            pending_next  = '0;
            rem_next      = '0;
            col_next      = '0;
            row_next      = '0;
            plane_next    = '0;
            row_base_next = '0;
            addr_next     = '0;
        end else begin
            if (cmd.latch_count) begin
                pending_next = s_code_byte[RB-1:0];
            end
            if (cmd.run_start) begin
                value_next = s_code_byte;
            end
            if (cmd.emit) begin
                out_valid_next = 1'b1;
                if (cmd.literal) begin
                    rem_next = '0;
                end else if (cmd.run_start) begin
                    rem_next = clip_n - RB'(1);
                end else begin
                    rem_next = rem_reg - RB'(1);
                end
                if (line_end) begin
                    col_next = '0;
                    if (plane_last) begin
                        plane_next    = '0;
                        row_base_next = next_base;
                        addr_next     = next_base;
                        row_next      = row_last ? '0 : row_reg + PB'(1);
                    end else begin
                        plane_next = plane_reg + 2'd1;
                        addr_next  = row_base_reg + AB'({1'b0, plane_reg} + 3'd1);
                    end
                end else begin
                    col_next  = col_reg + PB'(1);
                    addr_next = addr_reg + AB'(bpp_eff);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            rem_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            plane_reg     <= '0;
            row_base_reg  <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pending_reg   <= pending_next;
            rem_reg       <= rem_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            plane_reg     <= plane_next;
            row_base_reg  <= row_base_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (cmd.emit) begin
            out_value_reg    <= emit_value;
            out_col_reg      <= col_reg[prpd_pkg::OutPosBits-1:0];
            out_row_reg      <= row_reg[prpd_pkg::OutPosBits-1:0];
            out_plane_reg    <= plane_reg;
            out_addr_reg     <= addr_reg;
            out_last_reg     <= elem_last;
            out_complete_reg <= elem_last && status.completes;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pixel_value    = out_value_reg;
    assign m_column         = out_col_reg;
    assign m_row            = out_row_reg;
    assign m_plane          = out_plane_reg;
    assign m_byte_address   = out_addr_reg;
    assign m_last_of_run    = out_last_reg;
    assign m_image_complete = out_complete_reg;

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_ready))
        else $error("emit while result register is occupied");

    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < w_eff)
        else $error("column outside the line");

    a_complete_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_complete_reg) |-> out_last_reg)
        else $error("image end on a non-final result");

endmodule

`default_nettype wire

FILE: rtl/core/prpd_ctrl.sv
// Controller of the run-length plane decoder: code/value/run/done sequencing
// and input handshake. Drives datapath commands from its status.
// Depends on prpd_pkg.
`default_nettype none

module prpd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_restart,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire prpd_pkg::status_t  status,
    output prpd_pkg::cmd_t          cmd
);

    prpd_pkg::state_t state_reg, state_next;
    logic accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prpd_pkg::ST_CODE: begin
                if (accept) begin
                    if (status.is_run_code) begin
                        state_next = prpd_pkg::ST_VALUE;
                    end else if (status.completes) begin
                        state_next = prpd_pkg::ST_DONE;
                    end
                end
            end
            prpd_pkg::ST_VALUE: begin
                if (accept) begin
                    if (status.run_empty) begin
                        state_next = prpd_pkg::ST_CODE;
                    end else if (status.run_single) begin
                        state_next = status.completes ? prpd_pkg::ST_DONE : prpd_pkg::ST_CODE;
                    end else begin
                        state_next = prpd_pkg::ST_RUN;
                    end
                end
            end
            prpd_pkg::ST_RUN: begin
                if (status.out_free && status.run_last) begin
                    state_next = status.completes ? prpd_pkg::ST_DONE : prpd_pkg::ST_CODE;
                end
            end
            prpd_pkg::ST_DONE: state_next = prpd_pkg::ST_DONE;
            default: state_next = prpd_pkg::ST_CODE;
        endcase
        if (cfg_restart) begin
            state_next = prpd_pkg::ST_CODE;
        end
    end

    always_comb begin
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.restart     = cfg_restart;
        case (state_reg)
            prpd_pkg::ST_CODE: begin
                s_ready         = status.out_free;
                cmd.latch_count = accept && status.is_run_code;
                cmd.literal     = accept && !status.is_run_code;
                cmd.emit        = accept && !status.is_run_code;
            end
            prpd_pkg::ST_VALUE: begin
                s_ready       = status.out_free;
                cmd.run_start = accept;
                cmd.emit      = accept && !status.run_empty;
            end
            prpd_pkg::ST_RUN: begin
                cmd.emit = status.out_free;
            end
            prpd_pkg::ST_DONE: begin
                s_ready = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prpd_pkg::ST_CODE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_input_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prpd_pkg::ST_RUN) |-> !s_ready)
        else $error("input taken during a run");

    a_quiet_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prpd_pkg::ST_DONE) |-> !cmd.emit)
        else $error("result after image end");

    a_run_from_value: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(state_reg == prpd_pkg::ST_RUN) && !$past(cfg_restart))
            |-> $past(state_reg == prpd_pkg::ST_VALUE))
        else $error("run entered without a value byte");

endmodule

`default_nettype wire

FILE: rtl/core/pcx_rle_plane_decoder_core.sv
// Run-length plane decoder, top level.
// Input: s_valid/s_ready carry one code byte per transfer (s_code_byte).
// Output: m_valid/m_ready carry one decoded byte per transfer with its column,
// row, plane, interleaved buffer address and end-of-run / end-of-image flags.
// Config: cfg_we/cfg_index/cfg_wdata write image_width (0), image_height (1),
// plane_count (2), bytes_per_pixel (3); any such write restarts the walk.
// Timing: a literal byte appears on m_* in the cycle after its transfer.
// Throughput, while m_ready is high: literals one per cycle; a run code plus
// value byte yields its clipped count of results at one per cycle, first in
// the cycle after the value byte, with s_ready low until the run counter
// reaches its last result. A run code and a zero-length run give no result.
// Receiver stall: the single result register holds; s_ready drops until the
// result is taken. After the image ends, further bytes are taken and dropped.
// Reset: aresetn (synchronous, active low) restores the register defaults
// (width 1, height 1, 3 planes, 3 bytes per pixel) and restarts the walk.
// Depends on prpd_pkg, prpd_ctrl, prpd_datapath.
`default_nettype none

module pcx_rle_plane_decoder_core #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [prpd_pkg::CfgIdxBits-1:0]       cfg_index,
    input  wire logic [prpd_pkg::CfgWidth-1:0]         cfg_wdata,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [7:0]                            s_code_byte,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [7:0]                                 m_pixel_value,
    output logic [prpd_pkg::OutPosBits-1:0]            m_column,
    output logic [prpd_pkg::OutPosBits-1:0]            m_row,
    output logic [1:0]                                 m_plane,
    output logic [prpd_pkg::AddrBits-1:0]              m_byte_address,
    output logic                                       m_last_of_run,
    output logic                                       m_image_complete
);

    prpd_pkg::cmd_t    cmd;
    prpd_pkg::status_t status;
    logic              cfg_restart;

    assign cfg_restart = cfg_we && (cfg_index == prpd_pkg::REG_IMAGE_WIDTH
                                 || cfg_index == prpd_pkg::REG_IMAGE_HEIGHT
                                 || cfg_index == prpd_pkg::REG_PLANE_COUNT
                                 || cfg_index == prpd_pkg::REG_BYTES_PER_PIXEL);

    prpd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_restart (cfg_restart),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    prpd_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_code_byte      (s_code_byte),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_value    (m_pixel_value),
        .m_column         (m_column),
        .m_row            (m_row),
        .m_plane          (m_plane),
        .m_byte_address   (m_byte_address),
        .m_last_of_run    (m_last_of_run),
        .m_image_complete (m_image_complete)
    );

endmodule

`default_nettype wire
